// ----- rtl/mrpf_pkg.sv -----
`default_nettype none
package mrpf_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int STORE_DEPTH  = 16;
  localparam int WORD_BITS    = 32;

  localparam int SEQ_W     = 16;
  localparam int CH_W      = 3;
  localparam int IO_WORD_W = 32;
  localparam int CFG_W     = 8;
  localparam int STATUS_W  = 2;

  localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int ADDR_W   = $clog2(STORE_DEPTH);
  localparam int CNT_W    = $clog2(STORE_DEPTH + 1);

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_UPSTREAM = 2'd1,
    STAT_DISABLED    = 2'd2,
    STAT_FULL        = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic    taken;
    logic    fwd;
  } result_t;

  typedef enum logic {
    FSM_IDLE,
    FSM_RESP
  } fsm_t;

endpackage
`default_nettype wire

// ----- rtl/mrpf_ram.sv -----
`default_nettype none
module mrpf_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 4
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- rtl/mrpf_core.sv -----
`default_nettype none
module mrpf_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [mrpf_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                             acc,
  input  wire logic [mrpf_pkg::CH_W-1:0]        ch,
  input  wire logic                             up_valid,
  input  wire logic [mrpf_pkg::WORD_BITS-1:0]   up_word,
  output mrpf_pkg::result_t                     res,
  output logic                                  ram_we,
  output logic      [mrpf_pkg::ADDR_W-1:0]      ram_waddr,
  output logic      [mrpf_pkg::WORD_BITS-1:0]   ram_wdata,
  output logic                                  ram_re,
  output logic      [mrpf_pkg::ADDR_W-1:0]      ram_raddr
);

  localparam int NCH    = mrpf_pkg::NUM_CHANNELS;
  localparam int SEQ_W  = mrpf_pkg::SEQ_W;
  localparam int ADDR_W = mrpf_pkg::ADDR_W;
  localparam int CNT_W  = mrpf_pkg::CNT_W;
  localparam int IDX_W  = mrpf_pkg::CH_IDX_W;

  logic [mrpf_pkg::CFG_W-1:0] enabled_r;
  logic [SEQ_W-1:0]           rc_r [NCH];
  logic [SEQ_W-1:0]           rc_nxt [NCH];
  logic [CNT_W-1:0]           stored_r, stored_nxt, stored_step;
  logic [SEQ_W-1:0]           mark_r, mark_nxt, mark_inc;
  logic [NCH-1:0]             passed_r, passed_nxt, passed_set, rebuilt;
  logic [ADDR_W-1:0]          front_r, front_nxt;

  logic [NCH-1:0]   en, ch_bit;
  logic             ch_ok, ch_en, snap, need, full;
  logic [IDX_W-1:0] ch_idx;
  logic [SEQ_W-1:0] base, cnt, rel, cnt_eff, new_cnt;
  logic [CNT_W-1:0] rel_eff;

  function automatic logic [ADDR_W-1:0] slot(input logic [ADDR_W-1:0] fr,
                                             input logic [CNT_W-1:0] off);
    logic [ADDR_W:0] sum;
    sum = {1'b0, fr} + (ADDR_W+1)'(off);
    if (sum >= (ADDR_W+1)'(mrpf_pkg::STORE_DEPTH)) begin
      sum = sum - (ADDR_W+1)'(mrpf_pkg::STORE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  assign en      = NCH'({24'b0, enabled_r});
  assign ch_ok   = 32'(ch) < NCH;
  assign ch_idx  = IDX_W'(ch);
  assign ch_bit  = NCH'(1) << ch_idx;
  assign ch_en   = ch_ok && en[ch_idx];
  assign base    = mark_r - SEQ_W'(1);
  assign cnt     = rc_r[ch_idx];
  assign rel     = cnt - base;
  assign snap    = rel > SEQ_W'(stored_r);
  assign rel_eff = snap ? '0 : CNT_W'(rel);
  assign cnt_eff = snap ? base : cnt;
  assign new_cnt = cnt_eff + SEQ_W'(1);
  assign need    = rel_eff == stored_r;
  assign full    = stored_r >= CNT_W'(mrpf_pkg::STORE_DEPTH);
  assign mark_inc = mark_r + SEQ_W'(1);
  assign passed_set = passed_r | ch_bit;

  assign ram_waddr = slot(front_r, stored_r);
  assign ram_raddr = slot(front_r, rel_eff);
  assign ram_wdata = up_word;

  // passed mask after a shift, seen against the advanced mark
  always_comb begin
    logic [SEQ_W-1:0] cc, d;
    for (int c = 0; c < NCH; c++) begin
      cc = (IDX_W'(c) == ch_idx) ? new_cnt : rc_r[c];
      d  = cc - mark_inc;
      rebuilt[c] = en[c] && (d != '0) && !d[SEQ_W-1];
    end
  end

  always_comb begin
    rc_nxt      = rc_r;
    stored_nxt  = stored_r;
    stored_step = stored_r + CNT_W'(need);
    mark_nxt    = mark_r;
    passed_nxt  = passed_r;
    front_nxt   = front_r;
    res.status  = mrpf_pkg::STAT_OK;
    res.taken   = 1'b0;
    res.fwd     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    if (!ch_en) begin
      res.status = mrpf_pkg::STAT_DISABLED;
    end else begin
      rc_nxt[ch_idx] = cnt_eff;
      if (need && !up_valid) begin
        res.status = mrpf_pkg::STAT_NO_UPSTREAM;
      end else if (need && full) begin
        res.status = mrpf_pkg::STAT_FULL;
      end else begin
        res.taken      = need;
        res.fwd        = need;
        ram_we         = acc && need;
        ram_re         = acc && !need;
        stored_nxt     = stored_step;
        rc_nxt[ch_idx] = new_cnt;
        if (cnt_eff == mark_r) begin
          passed_nxt = passed_set;
          if (((passed_set & en) == en) && (stored_step >= CNT_W'(2))) begin
            front_nxt  = (front_r == ADDR_W'(mrpf_pkg::STORE_DEPTH - 1)) ?
                         '0 : front_r + ADDR_W'(1);
            stored_nxt = stored_step - CNT_W'(1);
            mark_nxt   = mark_inc;
            passed_nxt = rebuilt;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= mrpf_pkg::CFG_W'(1);
      stored_r  <= '0;
      mark_r    <= SEQ_W'(1);
      passed_r  <= '0;
      front_r   <= '0;
      for (int c = 0; c < NCH; c++) begin
        rc_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        enabled_r <= cfg_data;
      end
      if (acc) begin
        stored_r <= stored_nxt;
        mark_r   <= mark_nxt;
        passed_r <= passed_nxt;
        front_r  <= front_nxt;
        rc_r     <= rc_nxt;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/multi_reader_packet_fanout.sv -----
`default_nettype none
// Broadcast FIFO: one upstream word stream shared by up to eight reader
// channels, each with its own read position into a 16-word packet store.
// Every request returns exactly one result word. A request is accepted
// when the block is idle; its result is loaded into the output register
// in the RESP state, after the synchronous store read, so the block takes
// no new request until the previous result is loaded, which out_ready
// can hold off. cfg_data (enabled channel mask) is always ready and is
// to be written only while no request is in flight.
module multi_reader_packet_fanout (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [mrpf_pkg::CFG_W-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [mrpf_pkg::CH_W-1:0]         in_channel,
  input  wire logic                              in_upstream_valid,
  input  wire logic [mrpf_pkg::IO_WORD_W-1:0]    in_upstream_word,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [mrpf_pkg::STATUS_W-1:0]     out_status,
  output logic      [mrpf_pkg::IO_WORD_W-1:0]    out_packet_word,
  output logic                                   out_upstream_taken
);

  localparam int WB = mrpf_pkg::WORD_BITS;
  localparam int OW = mrpf_pkg::IO_WORD_W;

  mrpf_pkg::fsm_t    state_r, state_nxt;
  mrpf_pkg::result_t res, res_r;
  logic [WB-1:0]     up_word, word_r, rd_data;
  logic              acc, load;
  logic              ram_we, ram_re;
  logic [mrpf_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [WB-1:0]     ram_wdata;

  logic                          out_valid_r;
  logic [mrpf_pkg::STATUS_W-1:0] out_status_r;
  logic [OW-1:0]                 out_word_r;
  logic                          out_taken_r;

  assign cfg_ready = 1'b1;
  assign up_word   = WB'(in_upstream_word);
  assign acc       = in_valid && in_ready;

  mrpf_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .acc      (acc),
    .ch       (in_channel),
    .up_valid (in_upstream_valid),
    .up_word  (up_word),
    .res      (res),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr)
  );

  mrpf_ram #(
    .DEPTH (mrpf_pkg::STORE_DEPTH),
    .WIDTH (WB),
    .ADDR_W(mrpf_pkg::ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    load      = 1'b0;
    case (state_r)
      mrpf_pkg::FSM_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = mrpf_pkg::FSM_RESP;
        end
      end
      mrpf_pkg::FSM_RESP: begin
        if (!out_valid_r || out_ready) begin
          load      = 1'b1;
          state_nxt = mrpf_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = mrpf_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrpf_pkg::FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r  <= res;
      word_r <= up_word;
    end
    if (load) begin
      out_status_r <= res_r.status;
      out_taken_r  <= res_r.taken;
      if (res_r.status != mrpf_pkg::STAT_OK) begin
        out_word_r <= '0;
      end else if (res_r.fwd) begin
        out_word_r <= OW'(word_r);
      end else begin
        out_word_r <= OW'(rd_data);
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_packet_word    = out_word_r;
  assign out_upstream_taken = out_taken_r;

endmodule
`default_nettype wire

// ----- rtl/mrpf_checker.sv -----
`default_nettype none
module mrpf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_packet_word,
  input wire logic        out_upstream_taken
);

  a_err_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != mrpf_pkg::STAT_OK)) |-> (out_packet_word == 32'd0))
    else $error("nonzero word with error status");

  a_taken_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_upstream_taken) |-> (out_status == mrpf_pkg::STAT_OK))
    else $error("upstream taken on failed request");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_packet_word)
                                   && $stable(out_status)))
    else $error("stalled result changed");

endmodule

bind multi_reader_packet_fanout mrpf_checker u_mrpf_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_packet_word   (out_packet_word),
  .out_upstream_taken(out_upstream_taken)
);
`default_nettype wire

// ----- tb/sv/tb_multi_reader_packet_fanout.sv -----
`default_nettype none
module tb_multi_reader_packet_fanout;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT      = 1_000_000;
  localparam int PHASES     = 10;
  localparam int PHASE_REQS = 155;
  localparam int HOLD_OFF   = 300;

  typedef struct {
    logic [mrpf_pkg::CH_W-1:0]      ch;
    logic                           uv;
    logic [mrpf_pkg::IO_WORD_W-1:0] w;
  } req_t;

  typedef struct {
    mrpf_pkg::status_t              status;
    logic [mrpf_pkg::IO_WORD_W-1:0] word;
    logic                           taken;
  } fan_result_t;

  logic                           clk               = 1'b0;
  logic                           rst_n             = 1'b0;
  logic                           cfg_valid         = 1'b0;
  logic                           cfg_ready;
  logic [mrpf_pkg::CFG_W-1:0]     cfg_data          = '0;
  logic                           in_valid          = 1'b0;
  logic                           in_ready;
  logic [mrpf_pkg::CH_W-1:0]      in_channel        = '0;
  logic                           in_upstream_valid = 1'b0;
  logic [mrpf_pkg::IO_WORD_W-1:0] in_upstream_word  = '0;
  logic                           out_valid;
  logic                           out_ready         = 1'b0;
  logic [mrpf_pkg::STATUS_W-1:0]  out_status;
  logic [mrpf_pkg::IO_WORD_W-1:0] out_packet_word;
  logic                           out_upstream_taken;

  multi_reader_packet_fanout u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_channel         (in_channel),
    .in_upstream_valid  (in_upstream_valid),
    .in_upstream_word   (in_upstream_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_packet_word    (out_packet_word),
    .out_upstream_taken (out_upstream_taken)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // predictor state
  logic [mrpf_pkg::IO_WORD_W-1:0]    pkt_mem [mrpf_pkg::STORE_DEPTH];
  logic [mrpf_pkg::SEQ_W-1:0]        read_seq [mrpf_pkg::NUM_CHANNELS];
  logic [mrpf_pkg::SEQ_W-1:0]        mark_seq  = 16'd1;
  logic [mrpf_pkg::NUM_CHANNELS-1:0] passed = '0;
  int                                held      = 0;
  int                                head_slot = 0;
  logic [mrpf_pkg::CFG_W-1:0]        chan_mask = 8'h01;

  req_t        request_q [$];
  fan_result_t pending_results [$];

  int   fail_cnt    = 0;
  int   cycles      = 0;
  bit   no_gaps     = 1'b0;
  bit   pressure_on = 1'b0;
  bit   press_done  = 1'b0;
  int   press_cnt   = 0;
  int   stall_cnt   = 0;
  int   in_gap      = 0;
  logic in_fire     = 1'b0;
  req_t next_req;

  initial begin
    for (int c = 0; c < mrpf_pkg::NUM_CHANNELS; c++) read_seq[c] = '0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic fan_result_t serve_request(req_t r);
    fan_result_t                res;
    logic [mrpf_pkg::SEQ_W-1:0] base;
    logic [mrpf_pkg::SEQ_W-1:0] rel;
    logic [mrpf_pkg::SEQ_W-1:0] old;
    logic [mrpf_pkg::SEQ_W-1:0] d;
    res.status = mrpf_pkg::STAT_OK;
    res.word   = '0;
    res.taken  = 1'b0;
    if (!chan_mask[r.ch]) begin
      res.status = mrpf_pkg::STAT_DISABLED;
      return res;
    end
    base = mark_seq - 16'd1;
    rel  = read_seq[r.ch] - base;
    if (rel > mrpf_pkg::SEQ_W'(held)) begin
      read_seq[r.ch] = base;
      rel = '0;
    end
    if (rel == mrpf_pkg::SEQ_W'(held)) begin
      if (!r.uv) begin
        res.status = mrpf_pkg::STAT_NO_UPSTREAM;
        return res;
      end
      if (held >= mrpf_pkg::STORE_DEPTH) begin
        res.status = mrpf_pkg::STAT_FULL;
        return res;
      end
      pkt_mem[(head_slot + held) % mrpf_pkg::STORE_DEPTH] = r.w;
      held++;
      res.taken = 1'b1;
    end
    res.word = pkt_mem[(head_slot + int'(rel)) % mrpf_pkg::STORE_DEPTH];
    old = read_seq[r.ch];
    read_seq[r.ch] = old + 16'd1;
    if (old == mark_seq) begin
      passed[r.ch] = 1'b1;
      if ((passed & chan_mask) == chan_mask && held >= 2) begin
        head_slot = (head_slot + 1) % mrpf_pkg::STORE_DEPTH;
        held--;
        mark_seq = mark_seq + 16'd1;
        passed = '0;
        for (int c = 0; c < mrpf_pkg::NUM_CHANNELS; c++) begin
          d = read_seq[c] - mark_seq;
          if (chan_mask[c] && d != 0 && d < 16'h8000) passed[c] = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [mrpf_pkg::CH_W-1:0] pick_enabled(
      logic [mrpf_pkg::CFG_W-1:0] m);
    int c;
    c = $urandom_range(0, mrpf_pkg::NUM_CHANNELS - 1);
    while (!m[c]) c = $urandom_range(0, mrpf_pkg::NUM_CHANNELS - 1);
    return mrpf_pkg::CH_W'(c);
  endfunction

  task automatic push_req(logic [mrpf_pkg::CH_W-1:0] ch, logic uv,
                          logic [mrpf_pkg::IO_WORD_W-1:0] w);
    req_t r;
    r.ch = ch;
    r.uv = uv;
    r.w  = w;
    request_q.push_back(r);
  endtask

  task automatic wait_idle();
    while (request_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mask(logic [mrpf_pkg::CFG_W-1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    do @(posedge clk); while (!cfg_ready);
    chan_mask = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_fire)) begin
      if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (request_q.size() != 0) begin
        next_req = request_q.pop_front();
        in_valid          <= 1'b1;
        in_channel        <= next_req.ch;
        in_upstream_valid <= next_req.uv;
        in_upstream_word  <= next_req.w;
        in_gap            <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (press_cnt > 0) begin
      out_ready <= 1'b0;
      press_cnt <= press_cnt - 1;
    end else if (pressure_on && !press_done && in_valid) begin
      out_ready  <= 1'b0;
      press_done <= 1'b1;
      press_cnt  <= HOLD_OFF;
    end else if (stall_cnt > 0) begin
      out_ready <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      out_ready <= 1'b1;
      if (!no_gaps && $urandom_range(0, 4) == 0) stall_cnt <= gap_len();
    end
  end

  // accept tracking and result check
  always @(posedge clk) begin
    fan_result_t e;
    req_t        a;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word: status %0d, packet_word %h",
                 out_status, out_packet_word);
          fail_cnt++;
        end else begin
          e = pending_results.pop_front();
          if (out_status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, out_status);
            fail_cnt++;
          end
          if (out_packet_word !== e.word) begin
            $error("packet_word: expected %h, actual %h", e.word, out_packet_word);
            fail_cnt++;
          end
          if (out_upstream_taken !== e.taken) begin
            $error("upstream_taken: expected %0d, actual %0d", e.taken,
                   out_upstream_taken);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        a.ch = in_channel;
        a.uv = in_upstream_valid;
        a.w  = in_upstream_word;
        pending_results.push_back(serve_request(a));
      end
    end
  end

  initial begin
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [mrpf_pkg::CFG_W-1:0] m;
    logic [mrpf_pkg::CH_W-1:0]  fast;
    logic [mrpf_pkg::CH_W-1:0]  ch;
    int                         r;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset mask: only channel 0 reads
    push_req(3'd0, 1'b0, '0);
    push_req(3'd0, 1'b1, '0);
    push_req(3'd0, 1'b1, '1);
    push_req(3'd1, 1'b1, 32'h1234_5678);
    push_req(3'd7, 1'b1, 32'hFFFF_0000);
    wait_idle();

    // late-enabled channel snaps, then stalls so channel 0 fills the store
    write_mask(8'h03);
    push_req(3'd1, 1'b1, 32'hA5A5_A5A5);
    repeat (17) push_req(3'd0, 1'b1, $urandom);
    push_req(3'd0, 1'b0, '0);
    wait_idle();

    write_mask(8'h00);
    push_req(3'd0, 1'b1, $urandom);
    push_req(3'd5, 1'b0, '0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       m = 8'hFF;
        1:       m = 8'h01;
        2:       m = 8'h80;
        default: m = mrpf_pkg::CFG_W'($urandom_range(1, 255));
      endcase
      write_mask(m);
      pressure_on = (p == 4);
      no_gaps     = (p == 5);
      fast = pick_enabled(m);
      for (int n = 0; n < PHASE_REQS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          ch = mrpf_pkg::CH_W'($urandom_range(0, mrpf_pkg::NUM_CHANNELS - 1));
        end else if (r < 55) begin
          ch = fast;
        end else begin
          ch = pick_enabled(m);
        end
        push_req(ch, $urandom_range(0, 99) < 85, $urandom);
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fail_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
